### src/quadtree_cell_index_unit_defines.svh
// assertion macros for the quadtree cell index unit
`ifndef QUADTREE_CELL_INDEX_UNIT_DEFINES_SVH
`define QUADTREE_CELL_INDEX_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define QTCI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qtci assertion failed");

// next-cycle implication, checked out of reset
`define QTCI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qtci assertion failed");

`endif

### src/qtci_pkg.sv
// shared types and constants of the quadtree cell index unit
package qtci_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PADDR_W = 4;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_ORIGIN_X = 2'd0;
  localparam reg_idx_t REG_ORIGIN_Y = 2'd1;
  localparam reg_idx_t REG_SCALE_X  = 2'd2;
  localparam reg_idx_t REG_SCALE_Y  = 2'd3;

  localparam logic [DATA_W-1:0] SCALE_RESET = 32'h0001_0000;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

endpackage

### src/qtci_if.sv
// box and cell channel interfaces
interface qtci_box_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;

  modport source (output valid, box_min_x, box_min_y, box_max_x, box_max_y, input ready);
  modport sink (input valid, box_min_x, box_min_y, box_max_x, box_max_y, output ready);
endinterface

interface qtci_cell_if;
  logic       valid;
  logic       ready;
  logic [6:0] node_index;
  logic [1:0] tree_level;
  logic [5:0] cell_code;
  logic       clamped;

  modport source (output valid, node_index, tree_level, cell_code, clamped, input ready);
  modport sink (input valid, node_index, tree_level, cell_code, clamped, output ready);
endinterface

### src/qtci_axis_map.sv
// one coordinate: origin offset, scale multiply and saturation to the grid
module qtci_axis_map #(
  parameter int unsigned CELL_W = 3
) (
  input  logic                        clk_i,
  input  qtci_pkg::pipe_en_t          en_i,
  input  logic [qtci_pkg::DATA_W-1:0] coord_i,
  input  logic [qtci_pkg::DATA_W-1:0] origin_i,
  input  logic [qtci_pkg::DATA_W-1:0] scale_i,
  output logic [CELL_W-1:0]           cell_o,
  output logic                        clamp_o
);

  localparam int unsigned DW = qtci_pkg::DATA_W;

  logic [DW:0]     diff;
  logic            neg_q;
  logic [DW-1:0]   mag_q;
  logic [2*DW-1:0] prod;
  logic [DW-1:0]   prod_hi_q;
  logic            neg2_q;
  logic            scale_nz_q;
  logic [CELL_W-1:0] cell_d;
  logic            clamp_d;
  logic [CELL_W-1:0] cell_q;
  logic            clamp_q;

  // stage 1: exact 33-bit offset
  assign diff = {coord_i[DW-1], coord_i} - {origin_i[DW-1], origin_i};

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      neg_q <= diff[DW];
      mag_q <= diff[DW-1:0];
    end
  end

  // stage 2: 32x32 product, integer part kept
  assign prod = mag_q * scale_i;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_hi_q  <= prod[2*DW-1:DW];
      neg2_q     <= neg_q;
      scale_nz_q <= (scale_i != '0);
    end
  end

  // stage 3: saturate into the grid
  always_comb begin
    cell_d  = prod_hi_q[CELL_W-1:0];
    clamp_d = 1'b0;
    if (neg2_q) begin
      cell_d  = '0;
      clamp_d = scale_nz_q;
    end else if (prod_hi_q[DW-1:CELL_W] != '0) begin
      cell_d  = '1;
      clamp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      cell_q  <= cell_d;
      clamp_q <= clamp_d;
    end
  end

  assign cell_o  = cell_q;
  assign clamp_o = clamp_q;

endmodule

### src/quadtree_cell_index_unit.sv
// quadtree cell index unit: box in, linear quadtree node out
// Usage: a box beat on box_i carries four signed Q16.16 corner coordinates.
// Each result beat on cell_o carries the breadth-first node index, the tree
// level, the Morton cell code within that level and a flag set when any
// corner was saturated into the grid of 2^(LEVELS-1) cells per axis.
// Origin and scale must be written through the APB port only while no box
// is in flight; the block does not enforce this. pready is always high and
// reads return the register value. Throughput: one box per cycle while
// cell_o is ready, set by the four 32x32 multipliers of the second stage;
// the pipeline is offset, multiply, saturate, then level and index, with a
// valid bit per stage.
// When cell_o is stalled the last stage holds its beat and earlier stages
// keep filling bubbles; box_i.ready drops only once every stage is full.
// Reset empties the pipeline, sets both origins to zero and both scales to
// one cell per world unit.
`include "quadtree_cell_index_unit_defines.svh"

module quadtree_cell_index_unit #(
  parameter int unsigned LEVELS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  qtci_box_if.sink                       box_i,
  qtci_cell_if.source                    cell_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qtci_pkg::PADDR_W-1:0]   paddr,
  input  logic [qtci_pkg::DATA_W-1:0]    pwdata,
  output logic [qtci_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int unsigned DP     = LEVELS - 1;
  localparam int unsigned CODE_W = 2 * DP;
  localparam int unsigned LW     = $clog2(LEVELS);
  localparam int unsigned SH_W   = $clog2(CODE_W + 1);

  logic [qtci_pkg::DATA_W-1:0] origin_x_q, origin_y_q, scale_x_q, scale_y_q;
  qtci_pkg::reg_idx_t          reg_idx;
  logic                        wr_en;

  qtci_pkg::pipe_en_t en;
  logic               en4;
  logic               v1_q, v2_q, v3_q, v4_q;

  logic [DP-1:0] lx, ly, hx, hy;
  logic          clamp_lx, clamp_ly, clamp_hx, clamp_hy;

  logic [CODE_W-1:0] lo_code, hi_code, diff_code, code;
  logic [LW-1:0]     level;
  logic [SH_W-1:0]   shamt;
  logic [6:0]        start;

  logic [6:0] node_q;
  logic [1:0] level_q;
  logic [5:0] code_q;
  logic       clamp_q;

  // configuration registers
  assign reg_idx = paddr[qtci_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      scale_x_q  <= qtci_pkg::SCALE_RESET;
      scale_y_q  <= qtci_pkg::SCALE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        qtci_pkg::REG_ORIGIN_X: origin_x_q <= pwdata;
        qtci_pkg::REG_ORIGIN_Y: origin_y_q <= pwdata;
        qtci_pkg::REG_SCALE_X:  scale_x_q  <= pwdata;
        qtci_pkg::REG_SCALE_Y:  scale_y_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      qtci_pkg::REG_ORIGIN_X: prdata = origin_x_q;
      qtci_pkg::REG_ORIGIN_Y: prdata = origin_y_q;
      qtci_pkg::REG_SCALE_X:  prdata = scale_x_q;
      qtci_pkg::REG_SCALE_Y:  prdata = scale_y_q;
      default:                prdata = '0;
    endcase
  end

  // stage enables
  assign en4   = !v4_q || cell_o.ready;
  assign en.s3 = !v3_q || en4;
  assign en.s2 = !v2_q || en.s3;
  assign en.s1 = !v1_q || en.s2;
  assign box_i.ready = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= box_i.valid;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en4)   v4_q <= v3_q;
    end
  end

  // stages 1 to 3 per coordinate
  qtci_axis_map #(.CELL_W(DP)) u_map_lx (
    .clk_i, .en_i(en), .coord_i(box_i.box_min_x), .origin_i(origin_x_q),
    .scale_i(scale_x_q), .cell_o(lx), .clamp_o(clamp_lx)
  );
  qtci_axis_map #(.CELL_W(DP)) u_map_ly (
    .clk_i, .en_i(en), .coord_i(box_i.box_min_y), .origin_i(origin_y_q),
    .scale_i(scale_y_q), .cell_o(ly), .clamp_o(clamp_ly)
  );
  qtci_axis_map #(.CELL_W(DP)) u_map_hx (
    .clk_i, .en_i(en), .coord_i(box_i.box_max_x), .origin_i(origin_x_q),
    .scale_i(scale_x_q), .cell_o(hx), .clamp_o(clamp_hx)
  );
  qtci_axis_map #(.CELL_W(DP)) u_map_hy (
    .clk_i, .en_i(en), .coord_i(box_i.box_max_y), .origin_i(origin_y_q),
    .scale_i(scale_y_q), .cell_o(hy), .clamp_o(clamp_hy)
  );

  // stage 4: morton codes, level, node index
  always_comb begin
    for (int i = 0; i < DP; i++) begin
      lo_code[2*i]   = lx[i];
      lo_code[2*i+1] = ly[i];
      hi_code[2*i]   = hx[i];
      hi_code[2*i+1] = hy[i];
    end
  end

  assign diff_code = lo_code ^ hi_code;

  always_comb begin
    level = LW'(DP);
    for (int i = 0; i < DP; i++) begin
      if (diff_code[2*i +: 2] != 2'b00) level = LW'(DP - 1 - i);
    end
  end

  assign shamt = SH_W'(CODE_W) - (SH_W'(level) << 1);
  assign code  = hi_code >> shamt;

  always_comb begin
    start = '0;
    for (int k = 0; k < 4; k++) begin
      if (int'(level) > k) start[2*k] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      node_q  <= start + 7'(code);
      level_q <= 2'(level);
      code_q  <= 6'(code);
      clamp_q <= clamp_lx || clamp_ly || clamp_hx || clamp_hy;
    end
  end

  assign cell_o.valid      = v4_q;
  assign cell_o.node_index = node_q;
  assign cell_o.tree_level = level_q;
  assign cell_o.cell_code  = code_q;
  assign cell_o.clamped    = clamp_q;

  `QTCI_ASSERT_NEXT(a_accept_fills_s1, box_i.valid && box_i.ready, v1_q)
  `QTCI_ASSERT_IMPL(a_no_overwrite, v1_q && !en.s2, !box_i.ready)
  `QTCI_ASSERT_NEXT(a_out_advance, v4_q && cell_o.ready, v4_q == $past(v3_q))

endmodule

### dv/tb_quadtree_cell_index_unit.sv
// testbench of the quadtree cell index unit: directed box table, then random boxes
`timescale 1ns / 1ps

module tb_quadtree_cell_index_unit;

  localparam int unsigned LEVELS      = 4;
  localparam int unsigned DEPTH       = LEVELS - 1;
  localparam int unsigned CELL_MAX    = (1 << DEPTH) - 1;
  localparam int unsigned PHASE_BOXES = 180;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned IDLE_PCT    = 27;
  localparam int unsigned Q16_ONE     = 65536;

  typedef struct packed {
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] max_x;
    logic [31:0] max_y;
  } box_t;

  typedef struct packed {
    logic [6:0] node_index;
    logic [1:0] tree_level;
    logic [5:0] cell_code;
    logic       clamped;
  } cell_t;

  typedef struct packed {
    logic [31:0] org_x;
    logic [31:0] org_y;
    logic [31:0] scl_x;
    logic [31:0] scl_y;
  } grid_cfg_t;

  typedef struct packed {
    box_t  box;
    bit    typed;
    cell_t want;
  } dir_row_t;

  localparam cell_t NO_CELL = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [qtci_pkg::PADDR_W-1:0] paddr;
  logic [qtci_pkg::DATA_W-1:0]  pwdata;
  logic [qtci_pkg::DATA_W-1:0]  prdata;
  logic        pready;

  qtci_box_if  box_if ();
  qtci_cell_if cell_if ();

  quadtree_cell_index_unit #(
    .LEVELS (LEVELS)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .box_i   (box_if),
    .cell_o  (cell_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  grid_cfg_t   grid_cfg = '{32'h0, 32'h0, qtci_pkg::SCALE_RESET, qtci_pkg::SCALE_RESET};
  cell_t       pending_cells [$];
  int unsigned mismatches   = 0;
  int unsigned cells_seen   = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on      = 1'b1;

  // corners in Q16.16; typed rows hold results read straight off the scheme
  dir_row_t dir_tab [18] = '{
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1,
      '{7'd21, 2'd3, 6'd0, 1'b0}},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0007_0000, 32'h0007_0000}, 1'b1,
      '{7'd0, 2'd0, 6'd0, 1'b0}},
    '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b1,
      '{7'd84, 2'd3, 6'd63, 1'b1}},
    '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b1,
      '{7'd21, 2'd3, 6'd0, 1'b1}},
    '{'{32'h0001_0000, 32'h0001_0000, 32'h0001_8000, 32'h0001_8000}, 1'b1,
      '{7'd24, 2'd3, 6'd3, 1'b0}},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000}, 1'b1,
      '{7'd5, 2'd2, 6'd0, 1'b0}},
    '{'{32'h0002_0000, 32'h0002_0000, 32'h0003_0000, 32'h0003_0000}, 1'b1,
      '{7'd8, 2'd2, 6'd3, 1'b0}},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0003_0000, 32'h0003_0000}, 1'b1,
      '{7'd1, 2'd1, 6'd0, 1'b0}},
    '{'{32'h0004_0000, 32'h0004_0000, 32'h0007_0000, 32'h0007_0000}, 1'b1,
      '{7'd4, 2'd1, 6'd3, 1'b0}},
    '{'{32'h0007_0000, 32'h0007_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1,
      '{7'd0, 2'd0, 6'd0, 1'b0}},
    '{'{32'h0005_0000, 32'h0005_0000, 32'h0004_0000, 32'h0004_0000}, 1'b0, NO_CELL},
    '{'{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1,
      '{7'd21, 2'd3, 6'd0, 1'b1}},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0008_0000, 32'h0000_0000}, 1'b1,
      '{7'd0, 2'd0, 6'd0, 1'b1}},
    '{'{32'h0007_FFFF, 32'h0007_FFFF, 32'h0007_FFFF, 32'h0007_FFFF}, 1'b1,
      '{7'd84, 2'd3, 6'd63, 1'b0}},
    '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, NO_CELL},
    '{'{32'h0000_0000, 32'h0006_0000, 32'h0001_0000, 32'h0007_0000}, 1'b0, NO_CELL},
    '{'{32'h0003_0000, 32'h0005_FFFF, 32'h0006_0000, 32'h0005_0000}, 1'b0, NO_CELL},
    '{'{32'hFFFF_0000, 32'h0007_0000, 32'h0002_0000, 32'h7FFF_0000}, 1'b0, NO_CELL}
  };

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // top bit flags saturation, the rest is the deepest-level cell
  function automatic logic [DEPTH:0] axis_cell(logic [31:0] coord, logic [31:0] org,
                                               logic [31:0] scale);
    logic [32:0] offs;
    logic [65:0] prod;
    offs = {coord[31], coord} - {org[31], org};
    if (offs[32]) return {scale != 32'd0, DEPTH'(0)};
    prod = {34'd0, offs[31:0]} * {34'd0, scale};
    if (prod[65:32] > CELL_MAX) return {1'b1, DEPTH'(CELL_MAX)};
    return {1'b0, prod[32 +: DEPTH]};
  endfunction

  function automatic cell_t locate_node(box_t b);
    logic [DEPTH:0]     lx, ly, hx, hy;
    logic [2*DEPTH-1:0] lo_code, hi_code, diff, code;
    int unsigned        lvl, base, k;
    cell_t              r;
    lx = axis_cell(b.min_x, grid_cfg.org_x, grid_cfg.scl_x);
    ly = axis_cell(b.min_y, grid_cfg.org_y, grid_cfg.scl_y);
    hx = axis_cell(b.max_x, grid_cfg.org_x, grid_cfg.scl_x);
    hy = axis_cell(b.max_y, grid_cfg.org_y, grid_cfg.scl_y);
    for (k = 0; k < DEPTH; k++) begin
      lo_code[2*k]   = lx[k];
      lo_code[2*k+1] = ly[k];
      hi_code[2*k]   = hx[k];
      hi_code[2*k+1] = hy[k];
    end
    diff = lo_code ^ hi_code;
    lvl  = DEPTH;
    for (k = 0; k < DEPTH; k++) begin
      if (diff[2*k +: 2] != 2'b00) lvl = DEPTH - 1 - k;
    end
    code = hi_code >> (2 * (DEPTH - lvl));
    base = ((1 << (2 * lvl)) - 1) / 3;
    r.node_index = 7'(base + code);
    r.tree_level = 2'(lvl);
    r.cell_code  = 6'(code);
    r.clamped    = lx[DEPTH] | ly[DEPTH] | hx[DEPTH] | hy[DEPTH];
    return r;
  endfunction

  // world coordinate landing at position pos (Q16.16 cells) from the origin
  function automatic logic [31:0] place_coord(logic [31:0] org, logic [31:0] scale, int pos);
    longint offs;
    if (scale == 32'd0) return $urandom;
    offs = (longint'(pos) * Q16_ONE) / longint'(scale);
    return org + offs[31:0];
  endfunction

  function automatic logic [63:0] random_span(logic [31:0] org, logic [31:0] scale);
    int lo_pos, extent;
    lo_pos = int'($urandom_range(0, 10 * Q16_ONE)) - int'(Q16_ONE);
    extent = int'($urandom_range(0, 8 * Q16_ONE) >> $urandom_range(0, 19));
    return {place_coord(org, scale, lo_pos + extent), place_coord(org, scale, lo_pos)};
  endfunction

  function automatic box_t random_box();
    logic [63:0] sx, sy;
    box_t        b;
    if ($urandom_range(99) < 30) return '{$urandom, $urandom, $urandom, $urandom};
    sx = random_span(grid_cfg.org_x, grid_cfg.scl_x);
    sy = random_span(grid_cfg.org_y, grid_cfg.scl_y);
    b  = '{sx[31:0], sy[31:0], sx[63:32], sy[63:32]};
    if ($urandom_range(9) == 0) b = '{b.max_x, b.max_y, b.min_x, b.min_y};
    return b;
  endfunction

  function automatic grid_cfg_t phase_setting(int unsigned p);
    case (p)
      0: return '{32'h0, 32'h0, qtci_pkg::SCALE_RESET, qtci_pkg::SCALE_RESET};
      1: return '{32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000,
                  32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000,
                  qtci_pkg::SCALE_RESET, qtci_pkg::SCALE_RESET};
      2: return '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      3: return '{$urandom, $urandom, 32'h0, 32'h0};
      4: return '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h1};
      5: return '{$urandom, $urandom, $urandom, $urandom};
      6: return '{32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000,
                  32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000,
                  32'($urandom_range(32'h4000, 32'h8_0000)),
                  32'($urandom_range(32'h4000, 32'h8_0000))};
      default: return '{$urandom, $urandom,
                        32'($urandom_range(32'h100, 32'h100_0000)),
                        32'($urandom_range(32'h100, 32'h100_0000))};
    endcase
  endfunction

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("cell beat %0d: %s expected %0d, got %0d", cells_seen, what, want, got);
  endfunction

  task automatic apb_write(qtci_pkg::reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      qtci_pkg::REG_ORIGIN_X: grid_cfg.org_x = val;
      qtci_pkg::REG_ORIGIN_Y: grid_cfg.org_y = val;
      qtci_pkg::REG_SCALE_X:  grid_cfg.scl_x = val;
      qtci_pkg::REG_SCALE_Y:  grid_cfg.scl_y = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic put_box(box_t b, bit typed, cell_t want);
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        box_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    box_if.valid     <= 1'b1;
    box_if.box_min_x <= b.min_x;
    box_if.box_min_y <= b.min_y;
    box_if.box_max_x <= b.max_x;
    box_if.box_max_y <= b.max_y;
    do @(posedge clk_i); while (!box_if.ready);
    pending_cells.insert(pending_cells.size(), typed ? want : locate_node(b));
  endtask

  task automatic drain_cells();
    box_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cells.size() != 0);
  endtask

  always @(posedge clk_i) begin
    cell_if.ready <= (gaps_on && $urandom_range(99) < IDLE_PCT) ? 1'b0 : 1'b1;
  end

  always @(posedge clk_i) begin
    cell_t got, want;
    if (rst_ni && cell_if.valid && cell_if.ready) begin
      got = '{cell_if.node_index, cell_if.tree_level, cell_if.cell_code, cell_if.clamped};
      if (pending_cells.size() == 0) begin
        note_mismatch("unrequested beat, node_index", 0, got.node_index);
      end else begin
        want = pending_cells.pop_front();
        if (got.node_index !== want.node_index)
          note_mismatch("node_index", want.node_index, got.node_index);
        if (got.tree_level !== want.tree_level)
          note_mismatch("tree_level", want.tree_level, got.tree_level);
        if (got.cell_code !== want.cell_code)
          note_mismatch("cell_code", want.cell_code, got.cell_code);
        if (got.clamped !== want.clamped)
          note_mismatch("clamped", want.clamped, got.clamped);
      end
      cells_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (box_if.valid && box_if.ready) || (cell_if.valid && cell_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_quadtree_cell_index_unit: FAIL");
      $finish;
    end
  end

  initial begin
    grid_cfg_t next_cfg;
    int unsigned p, n;
    rst_ni           <= 1'b0;
    box_if.valid     <= 1'b0;
    box_if.box_min_x <= '0;
    box_if.box_min_y <= '0;
    box_if.box_max_x <= '0;
    box_if.box_max_y <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) put_box(dir_tab[i].box, dir_tab[i].typed, dir_tab[i].want);

    for (p = 0; p < N_PHASES; p++) begin
      drain_cells();
      next_cfg = phase_setting(p);
      apb_write(qtci_pkg::REG_ORIGIN_X, next_cfg.org_x);
      apb_write(qtci_pkg::REG_ORIGIN_Y, next_cfg.org_y);
      apb_write(qtci_pkg::REG_SCALE_X, next_cfg.scl_x);
      apb_write(qtci_pkg::REG_SCALE_Y, next_cfg.scl_y);
      // one phase runs with both sides streaming flat out
      gaps_on = (p != 6);
      for (n = 0; n < PHASE_BOXES; n++) begin
        if (p == 1 && n == PHASE_BOXES / 2) drain_cells();
        put_box(random_box(), 1'b0, NO_CELL);
      end
    end

    drain_cells();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_cells.size() == 0)
      $display("tb_quadtree_cell_index_unit: PASS");
    else
      $display("tb_quadtree_cell_index_unit: FAIL");
    $finish;
  end

endmodule
